### rtl/core/htlc_pkg.sv
package htlc_pkg;

    // Pixel count limit, default for the top-level parameter
    localparam int MAX_PIXELS_DEF = 65536;

    // Fixed-point reciprocal format
    localparam int FRAC_BITS = 12;
    localparam int CH_W      = 8;

    // Divider and datapath widths
    localparam int DIV_NUM_W = 20;                      // (255 << 12) + 127 fits
    localparam int SDEN_W    = CH_W;                    // max channel
    localparam int HDEN_W    = 11;                      // 6 * diff
    localparam int HDIV_W    = 17;                      // hue reciprocal, diff >= 1
    localparam int RAW_W     = 12;                      // signed hue numerator, -255..1275
    localparam int PRODS_W   = CH_W + DIV_NUM_W;        // diff * sat reciprocal
    localparam int PRODH_W   = RAW_W + HDIV_W + 1;      // raw * hue reciprocal, signed
    localparam int HUE_W     = PRODH_W - FRAC_BITS;
    localparam int SAT_W     = PRODS_W + 1 - FRAC_BITS;

    // Verdict codes
    localparam logic [1:0] COLOR_NONE   = 2'd0;
    localparam logic [1:0] COLOR_RED    = 2'd1;
    localparam logic [1:0] COLOR_GREEN  = 2'd2;
    localparam logic [1:0] COLOR_YELLOW = 2'd3;

    // Register map
    localparam logic       REG_SHARE_DIVISOR = 1'b0;
    localparam logic [7:0] DIVISOR_RESET     = 8'd50;

    // Per-pixel classification passed from the converter to the counters
    typedef struct packed {
        logic last;
        logic red;
        logic green;
        logic yellow;
    } pix_class_t;

endpackage

### rtl/core/hsv_traffic_light_color_classifier.sv
// Traffic-light colour classifier over a region of interest.
// Input stream (s_*): one BGR pixel per transfer, s_tlast marks the last
// pixel of the region. Each pixel is converted to 8-bit HSV (hue 0..179)
// and tested against the red, green and yellow ranges; saturating counters
// keep the totals.
// Output stream (m_*): one verdict per region, issued after the last pixel.
// A colour wins when its count times share_divisor exceeds the pixel total.
// Pixels are converted one at a time, a new one only after the last is
// handed off: the transfer, the two 20-step bit-serial reciprocal
// dividers that run in parallel, a check that both are done, the product
// step and the hand-off to the counters, which can stall. m_tvalid rises
// after the last pixel's conversion, the serial divisor multiply and compare.
// Reset (aresetn low, synchronous) clears all counts, drops m_tvalid and
// sets share_divisor to 50. When the receiver stalls, the verdict is held
// in the output register and pixels of the next region keep flowing; a
// second verdict then waits in the counters and holds back further pixels
// until the first one is taken. The user writes share_divisor over APB at
// address 0 only while the block is idle; the block leaves it unenforced.
module hsv_traffic_light_color_classifier import htlc_pkg::*; #(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue [7:0], green [15:8], red [23:16]
    input  logic        s_tlast,   // last_pixel
    // verdict output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // signal_color [1:0], stop [2], zero [7:3]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] divisor_reg;
    logic       cfg_wr;
    logic       pix_valid, pix_ready;
    pix_class_t pix;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= DIVISOR_RESET;
        end else if (cfg_wr && (paddr[2] == REG_SHARE_DIVISOR)) begin
            divisor_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_SHARE_DIVISOR) ? {24'b0, divisor_reg} : 32'b0;

    htlc_hsv u_hsv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    htlc_count #(.MAX_PIXELS(MAX_PIXELS)) u_count (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .pix           (pix),
        .share_divisor (divisor_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    // Stop flag agrees with the colour it is issued with
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == ((m_tdata[1:0] == COLOR_RED) ||
                                     (m_tdata[1:0] == COLOR_YELLOW))))
        else $error("stop flag does not match verdict colour");

    // Converter never offers a classified pixel while it takes a new one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pix_valid)
        else $error("converter ready while a pixel is still pending");

    // A divisor write reads back on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && (paddr[2] == REG_SHARE_DIVISOR)) |=>
            (paddr[2] != REG_SHARE_DIVISOR) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("share_divisor readback mismatch");

endmodule

### rtl/core/htlc_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
module htlc_div import htlc_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = HDEN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] work_reg, work_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    // One restoring step: bring down the next numerator bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, work_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        work_next = {work_reg[NUM_W-2:0], ge};
        cnt_next  = cnt_reg - CNT_W'(1);
        busy_next = (cnt_reg != CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            work_reg <= num;
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = work_reg;

endmodule

### rtl/core/htlc_hsv.sv
// BGR to HSV conversion and colour range test, one pixel at a time.
module htlc_hsv import htlc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    output logic        pix_valid,
    input  logic        pix_ready,
    output pix_class_t  pix
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [DIV_NUM_W-1:0] SAT_NUM  = DIV_NUM_W'(255 << FRAC_BITS);
    localparam logic [DIV_NUM_W-1:0] HUE_NUM  = DIV_NUM_W'(180 << FRAC_BITS);
    localparam int                   HALF     = 1 << (FRAC_BITS - 1);

    logic [1:0] state_reg, state_next;

    logic [CH_W-1:0] blue, green, red;
    logic [CH_W-1:0] mx, mn, diff;
    logic [HDEN_W-1:0] hden;
    logic signed [RAW_W-1:0] raw;
    logic accept;

    logic [CH_W-1:0]         mx_reg, diff_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic                    last_reg;
    logic [PRODS_W-1:0]      prod_s_reg;
    logic signed [PRODH_W-1:0] prod_h_reg;

    logic                 sdiv_busy, hdiv_busy;
    logic [DIV_NUM_W-1:0] sdiv_q, hdiv_q;

    logic [PRODS_W:0]          sat_sum;
    logic [SAT_W-1:0]          sat;
    logic signed [PRODH_W-1:0] hue_sum;
    logic signed [HUE_W-1:0]   hue_q, hue;

    function automatic logic in_box(
        input logic signed [HUE_W-1:0] h,
        input logic [SAT_W-1:0]        s,
        input logic [CH_W-1:0]         v,
        input logic signed [HUE_W-1:0] hl,
        input logic signed [HUE_W-1:0] hh,
        input logic [SAT_W-1:0]        sl,
        input logic [CH_W-1:0]         vl
    );
        in_box = (h >= hl) && (h <= hh) && (s >= sl) && (s <= SAT_W'(255)) && (v >= vl);
    endfunction

    assign blue  = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign red   = s_tdata[23:16];

    // Channel max/min and hue numerator by sector
    always_comb begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        diff = mx - mn;
        hden = HDEN_W'({diff, 2'b00}) + HDEN_W'({diff, 1'b0});
        if (mx == red)
            raw = $signed(RAW_W'(green)) - $signed(RAW_W'(blue));
        else if (mx == green)
            raw = $signed(RAW_W'(blue)) - $signed(RAW_W'(red))
                + $signed(RAW_W'({diff, 1'b0}));
        else
            raw = $signed(RAW_W'(red)) - $signed(RAW_W'(green))
                + $signed(RAW_W'({diff, 2'b00}));
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Rounded reciprocals 255/max and 180/(6*diff)
    htlc_div #(.NUM_W(DIV_NUM_W), .DEN_W(SDEN_W)) u_sdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .num     (SAT_NUM + DIV_NUM_W'(mx >> 1)),
        .den     (mx),
        .busy    (sdiv_busy),
        .quo     (sdiv_q)
    );

    htlc_div #(.NUM_W(DIV_NUM_W), .DEN_W(HDEN_W)) u_hdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .num     (HUE_NUM + DIV_NUM_W'(hden >> 1)),
        .den     (hden),
        .busy    (hdiv_busy),
        .quo     (hdiv_q)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DIV;
            ST_DIV:  if (!sdiv_busy && !hdiv_busy) state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  if (pix_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Pixel operands and products
    always_ff @(posedge aclk) begin
        if (accept) begin
            mx_reg   <= mx;
            diff_reg <= diff;
            raw_reg  <= raw;
            last_reg <= s_tlast;
        end
        if (state_reg == ST_MUL) begin
            prod_s_reg <= diff_reg * sdiv_q;
            prod_h_reg <= raw_reg * $signed({1'b0, hdiv_q[HDIV_W-1:0]});
        end
    end

    // Round, floor-shift and wrap; gray and black pixels force zero
    always_comb begin
        sat_sum = {1'b0, prod_s_reg} + (PRODS_W + 1)'(HALF);
        sat     = (mx_reg == '0) ? '0 : sat_sum[PRODS_W:FRAC_BITS];
        hue_sum = prod_h_reg + PRODH_W'(HALF);
        hue_q   = HUE_W'(hue_sum >>> FRAC_BITS);
        if (diff_reg == '0)
            hue = '0;
        else if (hue_q < 0)
            hue = hue_q + HUE_W'(180);
        else
            hue = hue_q;
    end

    // Range tests
    always_comb begin
        pix.last   = last_reg;
        pix.red    = in_box(hue, sat, mx_reg, HUE_W'(0), HUE_W'(5), SAT_W'(150), 8'd180)
                  || in_box(hue, sat, mx_reg, HUE_W'(170), HUE_W'(180), SAT_W'(150), 8'd180);
        pix.green  = in_box(hue, sat, mx_reg, HUE_W'(50), HUE_W'(85), SAT_W'(100), 8'd100);
        pix.yellow = in_box(hue, sat, mx_reg, HUE_W'(22), HUE_W'(30), SAT_W'(160), 8'd200);
    end

    assign pix_valid = (state_reg == ST_FIN);

endmodule

### rtl/core/htlc_count.sv
// Saturating pixel counters, bit-serial share test and verdict register.
module htlc_count import htlc_pkg::*; #(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pix_valid,
    output logic       pix_ready,
    input  pix_class_t pix,
    input  logic [7:0] share_divisor,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int PROD_W = CNT_W + CH_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_MUL = 2'd1;
    localparam logic [1:0] ST_CMP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [2:0] bit_reg, bit_next;

    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] red_reg, red_next;
    logic [CNT_W-1:0] green_reg, green_next;
    logic [CNT_W-1:0] yellow_reg, yellow_next;

    logic [PROD_W-1:0] acc_r_reg, acc_r_next;
    logic [PROD_W-1:0] acc_g_reg, acc_g_next;
    logic [PROD_W-1:0] acc_y_reg, acc_y_next;

    logic       m_valid_reg, m_valid_next;
    logic [1:0] color_reg, color_next;
    logic       stop_reg, stop_next;
    logic       load_out;
    logic [1:0] color;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c < CNT_MAX) ? c + CNT_W'(1) : CNT_MAX;
    endfunction

    assign pix_ready = (state_reg == ST_ACC);

    // Verdict priority: red, green, yellow
    always_comb begin
        if (acc_r_reg > PROD_W'(total_reg))
            color = COLOR_RED;
        else if (acc_g_reg > PROD_W'(total_reg))
            color = COLOR_GREEN;
        else if (acc_y_reg > PROD_W'(total_reg))
            color = COLOR_YELLOW;
        else
            color = COLOR_NONE;
    end

    always_comb begin
        state_next   = state_reg;
        bit_next     = bit_reg;
        total_next   = total_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        yellow_next  = yellow_reg;
        acc_r_next   = acc_r_reg;
        acc_g_next   = acc_g_reg;
        acc_y_next   = acc_y_reg;
        m_valid_next = m_valid_reg && !m_tready;
        color_next   = color_reg;
        stop_next    = stop_reg;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_ACC: begin
                if (pix_valid) begin
                    total_next = sat_inc(total_reg);
                    if (pix.red)    red_next    = sat_inc(red_reg);
                    if (pix.green)  green_next  = sat_inc(green_reg);
                    if (pix.yellow) yellow_next = sat_inc(yellow_reg);
                    if (pix.last) begin
                        state_next = ST_MUL;
                        bit_next   = 3'd7;
                        acc_r_next = '0;
                        acc_g_next = '0;
                        acc_y_next = '0;
                    end
                end
            end
            // count * divisor, divisor MSB first, one bit a cycle
            ST_MUL: begin
                acc_r_next = {acc_r_reg[PROD_W-2:0], 1'b0}
                           + (share_divisor[bit_reg] ? PROD_W'(red_reg) : '0);
                acc_g_next = {acc_g_reg[PROD_W-2:0], 1'b0}
                           + (share_divisor[bit_reg] ? PROD_W'(green_reg) : '0);
                acc_y_next = {acc_y_reg[PROD_W-2:0], 1'b0}
                           + (share_divisor[bit_reg] ? PROD_W'(yellow_reg) : '0);
                if (bit_reg == 3'd0)
                    state_next = ST_CMP;
                else
                    bit_next = bit_reg - 3'd1;
            end
            // Wait for the output slot, then issue and clear the counts
            ST_CMP: begin
                if (!m_valid_reg || m_tready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    color_next   = color;
                    stop_next    = (color == COLOR_RED) || (color == COLOR_YELLOW);
                    total_next   = '0;
                    red_next     = '0;
                    green_next   = '0;
                    yellow_next  = '0;
                    state_next   = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            bit_reg     <= '0;
            total_reg   <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            yellow_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            total_reg   <= total_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            yellow_reg  <= yellow_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Accumulators and result payload
    always_ff @(posedge aclk) begin
        acc_r_reg <= acc_r_next;
        acc_g_reg <= acc_g_next;
        acc_y_reg <= acc_y_next;
        if (load_out) begin
            color_reg <= color_next;
            stop_reg  <= stop_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, stop_reg, color_reg};

endmodule
